// File: rtl/core/sstab_pkg.sv
// Shared types and constants for the sparse-set component table.
// Used by the top level and its port checker; depends on nothing.
`default_nettype none

package sstab_pkg;

  // Table geometry
  localparam int NUM_TYPES     = 8;
  localparam int INST_CAPACITY = 256;
  localparam int TYPE_W        = $clog2(NUM_TYPES);
  localparam int INST_W        = $clog2(INST_CAPACITY);
  localparam int CNT_W         = INST_W + 1;
  localparam int ADDR_W        = TYPE_W + INST_W;
  localparam int DEPTH         = NUM_TYPES * INST_CAPACITY;

  // Operation codes
  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_OWNER  = 2'd3
  } action_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_UNREG  = 2'd1,
    STAT_ABSENT = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_DECODE,
    S_FWD_DATA,
    S_REV_DATA,
    S_LAST_DATA,
    S_OWN_DATA,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/sparse_set_component_table.sv
// Sparse-set component table: per-type forward and reverse maps with swap-remove.
// Depends on sstab_pkg; holds both map memories and the operation sequencer.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall   | action, comp_type, instance_req, slot_in
//   out_    | output    | out_valid / out_stall | status, slot_out, owner, moved,
//           |           |                       | move_from, live_count
//   cfg_    | input     | cfg_write_en          | registered_types
//
// One item at a time: in_stall stays high from acceptance until the result is loaded.
// Operations use the registered read ports of the two map memories: forward map,
// then reverse map, then the last slot's entry for a move; owner reads reverse only.
// After reset the forward map is swept, one entry a cycle, with in_stall high
// meanwhile. Configuration writes are taken at any time.
// A result waiting under out_stall does not block the next transfer in; that item
// then holds in its final state until the output register frees.
`default_nettype none

module sparse_set_component_table (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [2:0] in_comp_type,
  input  logic [7:0] in_instance_req,
  input  logic [7:0] in_slot_in,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_slot_out,
  output logic [7:0] out_owner,
  output logic       out_moved,
  output logic [7:0] out_move_from,
  output logic [8:0] out_live_count,
  // configuration
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_registered_types
);

  localparam int TW = sstab_pkg::TYPE_W;
  localparam int IW = sstab_pkg::INST_W;
  localparam int CW = sstab_pkg::CNT_W;
  localparam int AW = sstab_pkg::ADDR_W;
  localparam int NT = sstab_pkg::NUM_TYPES;

  // Sequencer and request registers
  sstab_pkg::state_t  state_r, state_nxt;
  logic [AW-1:0]      sweep_r;
  sstab_pkg::action_t act_r;
  logic [TW-1:0]      type_r;
  logic [IW-1:0]      inst_r;
  logic [IW-1:0]      slot_q_r;
  logic [IW-1:0]      s_r;

  // Per-type state
  logic [NT-1:0]      registered_r;
  logic [CW-1:0]      count_r [NT];

  // Result being built
  sstab_pkg::status_t res_status_r;
  logic [IW-1:0]      res_slot_r;
  logic [IW-1:0]      res_owner_r;
  logic               res_moved_r;
  logic [IW-1:0]      res_from_r;
  logic [CW-1:0]      res_count_r;

  // Output register
  logic               out_valid_r;
  sstab_pkg::status_t out_status_r;
  logic [IW-1:0]      out_slot_r;
  logic [IW-1:0]      out_owner_r;
  logic               out_moved_r;
  logic [IW-1:0]      out_from_r;
  logic [CW-1:0]      out_count_r;

  // Map memories: forward holds slot per instance, reverse holds instance per slot
  logic [IW-1:0]      fwd_mem [sstab_pkg::DEPTH];
  logic [IW-1:0]      rev_mem [sstab_pkg::DEPTH];
  logic [IW-1:0]      fwd_q, rev_q;
  logic [AW-1:0]      fwd_raddr, rev_raddr, fwd_waddr, rev_waddr;
  logic [IW-1:0]      fwd_wdata, rev_wdata;
  logic               fwd_we, rev_we;

  // Derived values
  logic               accept;
  logic               out_free;
  logic               is_reg;
  logic [CW-1:0]      cur_cnt;
  logic [CW-1:0]      last_cnt;
  logic               present;
  logic               has_room;
  logic               do_move;

  assign in_stall = (state_r != sstab_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign is_reg   = registered_r[type_r];
  assign cur_cnt  = count_r[type_r];
  assign last_cnt = cur_cnt - CW'(1);
  // membership holds when the forward slot is live and points back to this instance
  assign present  = ({1'b0, s_r} < cur_cnt) && (rev_q == inst_r);
  assign has_room = cur_cnt < CW'(sstab_pkg::INST_CAPACITY);
  assign do_move  = {1'b0, s_r} < last_cnt;

  // Memory ports
  always_ff @(posedge clk) begin
    if (fwd_we) begin
      fwd_mem[fwd_waddr] <= fwd_wdata;
    end
    fwd_q <= fwd_mem[fwd_raddr];
  end

  always_ff @(posedge clk) begin
    if (rev_we) begin
      rev_mem[rev_waddr] <= rev_wdata;
    end
    rev_q <= rev_mem[rev_raddr];
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sstab_pkg::S_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and memory port control
  always_comb begin
    state_nxt = state_r;
    fwd_raddr = {type_r, inst_r};
    rev_raddr = {type_r, slot_q_r};
    fwd_we    = 1'b0;
    fwd_waddr = {type_r, inst_r};
    fwd_wdata = cur_cnt[IW-1:0];
    rev_we    = 1'b0;
    rev_waddr = {type_r, cur_cnt[IW-1:0]};
    rev_wdata = inst_r;
    case (state_r)
      sstab_pkg::S_SWEEP: begin
        fwd_we    = 1'b1;
        fwd_waddr = sweep_r;
        fwd_wdata = '0;
        if (sweep_r == AW'(sstab_pkg::DEPTH - 1)) begin
          state_nxt = sstab_pkg::S_IDLE;
        end
      end
      sstab_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = sstab_pkg::S_DECODE;
        end
      end
      sstab_pkg::S_DECODE: begin
        if (!is_reg) begin
          state_nxt = sstab_pkg::S_DONE;
        end else if (act_r == sstab_pkg::ACT_OWNER) begin
          if ({1'b0, slot_q_r} < cur_cnt) begin
            state_nxt = sstab_pkg::S_OWN_DATA;
          end else begin
            state_nxt = sstab_pkg::S_DONE;
          end
        end else begin
          state_nxt = sstab_pkg::S_FWD_DATA;
        end
      end
      sstab_pkg::S_FWD_DATA: begin
        // check the reverse entry at the slot the forward map gives
        rev_raddr = {type_r, fwd_q};
        state_nxt = sstab_pkg::S_REV_DATA;
      end
      sstab_pkg::S_REV_DATA: begin
        state_nxt = sstab_pkg::S_DONE;
        if (act_r == sstab_pkg::ACT_ADD && !present && has_room) begin
          fwd_we = 1'b1;
          rev_we = 1'b1;
        end
        if (act_r == sstab_pkg::ACT_REMOVE && present && do_move) begin
          rev_raddr = {type_r, last_cnt[IW-1:0]};
          state_nxt = sstab_pkg::S_LAST_DATA;
        end
      end
      sstab_pkg::S_LAST_DATA: begin
        // last entry fills the freed slot, its forward entry follows
        rev_we    = 1'b1;
        rev_waddr = {type_r, s_r};
        rev_wdata = rev_q;
        fwd_we    = 1'b1;
        fwd_waddr = {type_r, rev_q};
        fwd_wdata = s_r;
        state_nxt = sstab_pkg::S_DONE;
      end
      sstab_pkg::S_OWN_DATA: begin
        state_nxt = sstab_pkg::S_DONE;
      end
      sstab_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = sstab_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sstab_pkg::S_IDLE;
      end
    endcase
  end

  // Sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (state_r == sstab_pkg::S_SWEEP) begin
      sweep_r <= sweep_r + AW'(1);
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= sstab_pkg::action_t'(in_action);
      type_r   <= in_comp_type;
      inst_r   <= in_instance_req;
      slot_q_r <= in_slot_in;
    end
    if (state_r == sstab_pkg::S_FWD_DATA) begin
      s_r <= fwd_q;
    end
  end

  // Registration mask and live counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      registered_r <= '0;
      for (int t = 0; t < NT; t++) begin
        count_r[t] <= '0;
      end
    end else begin
      if (cfg_write_en) begin
        registered_r <= cfg_registered_types[NT-1:0];
      end
      // unregistering a type empties it; stale map entries fail the membership check
      for (int t = 0; t < NT; t++) begin
        if (cfg_write_en && registered_r[t] && !cfg_registered_types[t]) begin
          count_r[t] <= '0;
        end else if (state_r == sstab_pkg::S_REV_DATA && type_r == TW'(t)) begin
          if (act_r == sstab_pkg::ACT_ADD && !present && has_room) begin
            count_r[t] <= cur_cnt + CW'(1);
          end else if (act_r == sstab_pkg::ACT_REMOVE && present) begin
            count_r[t] <= last_cnt;
          end
        end
      end
    end
  end

  // Result assembly
  always_ff @(posedge clk) begin
    case (state_r)
      sstab_pkg::S_DECODE: begin
        res_slot_r   <= '0;
        res_owner_r  <= '0;
        res_moved_r  <= 1'b0;
        res_from_r   <= '0;
        res_count_r  <= is_reg ? cur_cnt : '0;
        if (!is_reg) begin
          res_status_r <= sstab_pkg::STAT_UNREG;
        end else if (act_r == sstab_pkg::ACT_OWNER && !({1'b0, slot_q_r} < cur_cnt)) begin
          res_status_r <= sstab_pkg::STAT_ABSENT;
        end else begin
          res_status_r <= sstab_pkg::STAT_OK;
        end
      end
      sstab_pkg::S_REV_DATA: begin
        case (act_r)
          sstab_pkg::ACT_ADD: begin
            if (present) begin
              res_slot_r <= s_r;
            end else if (has_room) begin
              res_slot_r  <= cur_cnt[IW-1:0];
              res_count_r <= cur_cnt + CW'(1);
            end else begin
              res_status_r <= sstab_pkg::STAT_ABSENT;
            end
          end
          sstab_pkg::ACT_REMOVE: begin
            if (present) begin
              res_slot_r  <= s_r;
              res_count_r <= last_cnt;
              if (do_move) begin
                res_moved_r <= 1'b1;
                res_from_r  <= last_cnt[IW-1:0];
              end
            end else begin
              res_status_r <= sstab_pkg::STAT_ABSENT;
            end
          end
          default: begin
            if (present) begin
              res_slot_r <= s_r;
            end else begin
              res_status_r <= sstab_pkg::STAT_ABSENT;
            end
          end
        endcase
      end
      sstab_pkg::S_OWN_DATA: begin
        res_owner_r <= rev_q;
      end
      default: begin
      end
    endcase
  end

  // Output register: loaded from the result when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == sstab_pkg::S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sstab_pkg::S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_owner_r  <= res_owner_r;
      out_moved_r  <= res_moved_r;
      out_from_r   <= res_from_r;
      out_count_r  <= res_count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_out   = out_slot_r;
  assign out_owner      = out_owner_r;
  assign out_moved      = out_moved_r;
  assign out_move_from  = out_from_r;
  assign out_live_count = out_count_r;

endmodule

`default_nettype wire

// File: rtl/core/sstab_checker.sv
// Port-level checks for the sparse-set component table, bound to the top level.
// Depends on sstab_pkg and sparse_set_component_table.
`default_nettype none

module sstab_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_status,
  input logic [7:0] out_slot_out,
  input logic [7:0] out_owner,
  input logic       out_moved,
  input logic [7:0] out_move_from,
  input logic [8:0] out_live_count
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // One item at a time: busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // Unregistered type reports nothing else
  a_unreg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == sstab_pkg::STAT_UNREG |->
      out_slot_out == 8'd0 && out_owner == 8'd0 && !out_moved &&
      out_move_from == 8'd0 && out_live_count == 9'd0)
    else $error("unregistered result carries data");

  // A move comes from the old last slot, which is the new count
  a_move_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_moved |->
      out_status == sstab_pkg::STAT_OK && out_live_count == {1'b0, out_move_from} &&
      out_slot_out < out_move_from)
    else $error("inconsistent move report");

  // Count and status stay in range
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_live_count <= 9'd256 && out_status != 2'd3)
    else $error("result field out of range");

endmodule

bind sparse_set_component_table sstab_checker u_sstab_checker (.*);

`default_nettype wire
